### hdl/hft_pkg.sv
// hft_pkg: shared types, constants and codes for the huffman tree builder and decoder
// no dependencies; imported by hft_cell and huffman_tree_build_decode
`timescale 1ns / 1ps

package hft_pkg;

  localparam int MAX_SYMBOLS = 256;
  localparam int WEIGHT_BITS = 16;
  localparam int WSUM_BITS   = WEIGHT_BITS + 10;
  localparam int NODE_DEPTH  = 2 * MAX_SYMBOLS - 1;
  localparam int NODE_W      = $clog2(NODE_DEPTH);
  localparam int CNT_W       = $clog2(MAX_SYMBOLS + 1);
  localparam int SYM_W       = 8;
  localparam int KIND_W      = 2;

  typedef enum logic [KIND_W-1:0] {
    KIND_SYMBOL = 2'd0,
    KIND_BUILT  = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_t;

  typedef enum logic [0:0] {
    CMD_LOAD   = 1'b0,
    CMD_DECODE = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    CELL_HOLD  = 2'd0,
    CELL_LOAD  = 2'd1,
    CELL_MERGE = 2'd2
  } cell_op_t;

  // one list slot: node index and its weight
  typedef struct packed {
    logic                 valid;
    logic [NODE_W-1:0]    idx;
    logic [WSUM_BITS-1:0] w;
  } slot_t;

  // broadcast to every cell of the row
  typedef struct packed {
    cell_op_t             op;
    logic                 flush;
    logic [WSUM_BITS-1:0] key;
    slot_t                ins;
  } cell_ctrl_t;

  typedef struct packed {
    logic              leaf;
    logic [SYM_W-1:0]  sym;
    logic [NODE_W-1:0] c0;
    logic [NODE_W-1:0] c1;
  } node_t;

  localparam int NODE_BITS = $bits(node_t);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_BUILD = 4'b0010,
    ST_ROOT  = 4'b0100,
    ST_DEC   = 4'b1000
  } state_t;

endpackage

### hdl/huffman_tree_build_decode.sv
// huffman_tree_build_decode: top level, loads entries, builds the tree, decodes bits
// depends on hft_pkg, hft_cell (row of list cells) and hft_ram (node table)
`timescale 1ns / 1ps
//
// channel  dir  handshake               payload
// in_      in   in_tvalid / in_tready   tuser cmd, tlast last_entry, tdata symbol/weight/bit
// out_     out  out_tvalid / out_tready tuser kind, tdata symbol_out
//
// a load entry is put in place in the cell row as it arrives
// the build after the last entry merges the two lightest nodes until one is left, then reads the root
// a decode bit reads the child entry from the registered node ram
// a decode that errors or sits on a one-symbol tree answers without a read of the node ram
// reset clears the control state and the cell valid flags; the node ram needs no clear
// in_tready waits while a result cannot be placed into the output register

module huffman_tree_build_decode
  import hft_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [7:0] symbol_in, [23:8] weight, [24] code_bit
  input  logic        in_tlast,   // last_entry
  input  logic [0:0]  in_tuser,   // cmd
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] symbol_out
  output logic [1:0]  out_tuser   // kind
);

  state_t              state_r, state_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [NODE_W-1:0]   next_r, next_nxt;
  logic                ready_r, ready_nxt;
  node_t               cur_r, cur_nxt;
  node_t               root_r, root_nxt;
  logic                out_valid_r, out_valid_nxt;
  kind_t               out_kind_r, out_kind_nxt;
  logic [SYM_W-1:0]    out_sym_r, out_sym_nxt;

  logic                acc;
  logic                push;
  kind_t               push_kind;
  logic [SYM_W-1:0]    push_sym;
  logic [CNT_W-1:0]    cnt_eff;
  logic [WSUM_BITS-1:0] wext;
  logic [WSUM_BITS-1:0] wsum;

  cell_ctrl_t          ctrl;
  slot_t               slot_w [MAX_SYMBOLS];
  logic                lt_w   [MAX_SYMBOLS];

  logic                ram_we;
  logic [NODE_W-1:0]   ram_waddr, ram_raddr;
  node_t               ram_wdata, ram_rdata;

  assign in_tready  = (state_r == ST_IDLE) && (!out_valid_r || out_tready);
  assign acc        = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tdata  = out_sym_r;

  assign cnt_eff = ready_r ? '0 : cnt_r;
  assign wext    = {{(WSUM_BITS-WEIGHT_BITS){1'b0}}, in_tdata[8 +: WEIGHT_BITS]};
  assign wsum    = slot_w[0].w + slot_w[1].w;

  // row of list cells, cell 0 holds the lightest node
  for (genvar k = 0; k < MAX_SYMBOLS; k++) begin : g_cell
    slot_t lo_s, up1_s, up2_s;
    logic  lo_l, up1_l, up2_l;

    if (k == 0) begin : g_lo0
      assign lo_s  = '0;
      assign lo_l  = 1'b1;
      assign up1_l = 1'b1;   // boundary: merged node may land at the bottom
    end else begin : g_lo
      assign lo_s  = slot_w[k-1];
      assign lo_l  = lt_w[k-1];
    end

    if (k + 1 < MAX_SYMBOLS) begin : g_up1
      assign up1_s = slot_w[k+1];
      if (k != 0) begin : g_up1l
        assign up1_l = lt_w[k+1];
      end
    end else begin : g_up1n
      assign up1_s = '0;
      if (k != 0) begin : g_up1z
        assign up1_l = 1'b0;
      end
    end

    if (k + 2 < MAX_SYMBOLS) begin : g_up2
      assign up2_s = slot_w[k+2];
      assign up2_l = lt_w[k+2];
    end else begin : g_up2n
      assign up2_s = '0;
      assign up2_l = 1'b0;
    end

    hft_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .ctrl   (ctrl),
      .lo     (lo_s),
      .lo_lt  (lo_l),
      .up1    (up1_s),
      .up1_lt (up1_l),
      .up2    (up2_s),
      .up2_lt (up2_l),
      .slot_o (slot_w[k]),
      .lt_o   (lt_w[k])
    );
  end

  hft_ram #(
    .WIDTH (NODE_BITS),
    .DEPTH (NODE_DEPTH)
  ) u_nodes (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    next_nxt  = next_r;
    ready_nxt = ready_r;
    cur_nxt   = cur_r;
    root_nxt  = root_r;
    push      = 1'b0;
    push_kind = KIND_ERROR;
    push_sym  = '0;
    ctrl      = '0;
    ctrl.op   = CELL_HOLD;
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    ram_raddr = '0;

    case (state_r)
      ST_IDLE: begin
        if (acc && in_tuser == CMD_LOAD) begin
          if (cnt_eff >= CNT_W'(MAX_SYMBOLS)) begin
            // overfull: word dropped, mark ignored
            push      = 1'b1;
            push_kind = KIND_ERROR;
          end else begin
            ctrl.op        = CELL_LOAD;
            ctrl.flush     = ready_r;
            ctrl.key       = wext;
            ctrl.ins.valid = 1'b1;
            ctrl.ins.idx   = NODE_W'(cnt_eff);
            ctrl.ins.w     = wext;
            ram_we         = 1'b1;
            ram_waddr      = NODE_W'(cnt_eff);
            ram_wdata.leaf = 1'b1;
            ram_wdata.sym  = in_tdata[7:0];
            ready_nxt      = 1'b0;
            cnt_nxt        = cnt_eff + 1'b1;
            if (in_tlast) begin
              next_nxt  = NODE_W'(cnt_eff) + 1'b1;
              state_nxt = ST_BUILD;
            end
          end
        end else if (acc) begin
          if (!ready_r) begin
            push      = 1'b1;
            push_kind = KIND_ERROR;
          end else if (cur_r.leaf) begin
            // one-symbol tree
            push      = 1'b1;
            push_kind = KIND_SYMBOL;
            push_sym  = cur_r.sym;
          end else begin
            ram_raddr = in_tdata[24] ? cur_r.c1 : cur_r.c0;
            state_nxt = ST_DEC;
          end
        end
      end
      ST_BUILD: begin
        if (cnt_r > CNT_W'(1)) begin
          // merge the two lightest: heavier is child 0
          ctrl.op        = CELL_MERGE;
          ctrl.key       = wsum;
          ctrl.ins.valid = 1'b1;
          ctrl.ins.idx   = next_r;
          ctrl.ins.w     = wsum;
          ram_we         = 1'b1;
          ram_waddr      = next_r;
          ram_wdata.leaf = 1'b0;
          ram_wdata.c0   = slot_w[1].idx;
          ram_wdata.c1   = slot_w[0].idx;
          cnt_nxt        = cnt_r - 1'b1;
          next_nxt       = next_r + 1'b1;
        end else begin
          ram_raddr = slot_w[0].idx;
          state_nxt = ST_ROOT;
        end
      end
      ST_ROOT: begin
        cur_nxt   = ram_rdata;
        root_nxt  = ram_rdata;
        ready_nxt = 1'b1;
        push      = 1'b1;
        push_kind = KIND_BUILT;
        state_nxt = ST_IDLE;
      end
      ST_DEC: begin
        if (ram_rdata.leaf) begin
          push      = 1'b1;
          push_kind = KIND_SYMBOL;
          push_sym  = ram_rdata.sym;
          cur_nxt   = root_r;
        end else begin
          cur_nxt = ram_rdata;
        end
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // output register, always free when this item pushes
    out_valid_nxt = out_valid_r && !out_tready;
    out_kind_nxt  = out_kind_r;
    out_sym_nxt   = out_sym_r;
    if (push) begin
      out_valid_nxt = 1'b1;
      out_kind_nxt  = push_kind;
      out_sym_nxt   = push_sym;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      next_r      <= '0;
      ready_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      next_r      <= next_nxt;
      ready_r     <= ready_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cur_r      <= cur_nxt;
    root_r     <= root_nxt;
    out_kind_r <= out_kind_nxt;
    out_sym_r  <= out_sym_nxt;
  end

  // a built tree leaves exactly the root in the row
  a_ready_one: assert property (@(posedge clk) disable iff (!rst_n)
    ready_r |-> cnt_r == CNT_W'(1))
    else $error("tree ready with more than one list slot");

  a_build_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_BUILD |-> cnt_r != '0)
    else $error("build with empty list");

  a_dec_err: assert property (@(posedge clk) disable iff (!rst_n)
    acc && in_tuser == CMD_DECODE && !ready_r |=> out_valid_r && out_tuser == KIND_ERROR)
    else $error("decode before build not answered by error");

  a_sym_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_tuser != KIND_SYMBOL |-> out_tdata == '0)
    else $error("nonzero symbol on status word");

endmodule

### hdl/hft_ram.sv
// hft_ram: generic single write port ram with one registered read port
// no dependencies; holds the node table of the huffman tree
`timescale 1ns / 1ps

module hft_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hdl/hft_cell.sv
// hft_cell: one slot of the sorted node list, lightest slot at cell 0
// depends on hft_pkg; inserts or merges with data from its neighbors
`timescale 1ns / 1ps

module hft_cell
  import hft_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  cell_ctrl_t ctrl,
  input  slot_t      lo,
  input  logic       lo_lt,
  input  slot_t      up1,
  input  logic       up1_lt,
  input  slot_t      up2,
  input  logic       up2_lt,
  output slot_t      slot_o,
  output logic       lt_o
);

  slot_t slot_r;
  slot_t slot_nxt;
  slot_t own;

  always_comb begin
    own       = slot_r;
    own.valid = slot_r.valid & ~ctrl.flush;
  end

  assign slot_o = own;
  assign lt_o   = own.valid && (own.w < ctrl.key);

  always_comb begin
    case (ctrl.op)
      CELL_LOAD: begin
        // lighter slots stay, the new one lands above them, heavier and equal ones move up
        if (lt_o) begin
          slot_nxt = own;
        end else if (lo_lt) begin
          slot_nxt = ctrl.ins;
        end else begin
          slot_nxt = lo;
        end
      end
      CELL_MERGE: begin
        // two lightest leave, lighter ones move down two, merged node slots in, heavier and equal ones move down one
        if (up2_lt) begin
          slot_nxt = up2;
        end else if (up1_lt) begin
          slot_nxt = ctrl.ins;
        end else begin
          slot_nxt = up1;
        end
      end
      default: begin
        slot_nxt = slot_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r.valid <= 1'b0;
    end else begin
      slot_r.valid <= slot_nxt.valid;
    end
    slot_r.idx <= slot_nxt.idx;
    slot_r.w   <= slot_nxt.w;
  end

endmodule
